### rtl/latency_ratio_controller_core_defines.svh
// assertion helpers
`ifndef LATENCY_RATIO_CONTROLLER_CORE_DEFINES_SVH
`define LATENCY_RATIO_CONTROLLER_CORE_DEFINES_SVH

`define LRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/lrc_pkg.sv
package lrc_pkg;

  localparam int unsigned DIV_DW = 56;
  localparam int unsigned DIV_SW = 41;
  localparam int unsigned AVG_W  = 40;
  localparam logic [16:0] Q_ONE  = 17'd65536;

  localparam logic [2:0] REG_K_ERR  = 3'd0;
  localparam logic [2:0] REG_K_D    = 3'd1;
  localparam logic [2:0] REG_MIX    = 3'd2;
  localparam logic [2:0] REG_PERIOD = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/lrc_div.sv
module lrc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrc_pkg::div_cmd_t cmd_i,
  output lrc_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, done_q;
  logic [5:0]                   cnt_q;
  logic [lrc_pkg::DIV_SW-1:0]   rem_q, dvs_q;
  logic [lrc_pkg::DIV_DW-1:0]   quo_q;
  logic [lrc_pkg::DIV_SW:0]     rem_sh;
  logic                         ge;

  assign rem_sh = {rem_q, quo_q[lrc_pkg::DIV_DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(lrc_pkg::DIV_DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= '0;
      dvs_q <= cmd_i.divisor;
      quo_q <= cmd_i.dividend;
    end else if (busy_q) begin
      rem_q <= ge ? lrc_pkg::DIV_SW'(rem_sh - {1'b0, dvs_q}) : rem_sh[lrc_pkg::DIV_SW-1:0];
      quo_q <= {quo_q[lrc_pkg::DIV_DW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### rtl/latency_ratio_controller_core.sv
// Latency ratio controller. Each accepted sample of a provider below PROVIDERS updates that
// provider's running mean with one 56-step pass of the shared restoring divider, and the input
// is not ready until that pass is done. Every update_period-th sample then starts an update run
// over all PROVIDERS providers (none when update_period is zero). The window sum takes one cycle
// per window entry. A division of the window sum by the window width gives the reference mean.
// Each provider then needs one division for the relative latency and one for normalization.
// A division is skipped on a zero reference or a zero share sum. The run waits whenever the
// output is held. The input is not ready during this work.
// Ratios for providers 0 to 7 leave in provider order, tlast on the final one.
`include "latency_ratio_controller_core_defines.svh"

module latency_ratio_controller_core #(
  parameter int unsigned PROVIDERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // provider[2:0], latency_us[26:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // provider_out[2:0], ratio[19:3]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1;
  localparam logic [16:0] UNI = 17'(65536 / PROVIDERS);
  localparam logic [7:0]  OUT_LAST = 8'((PROVIDERS < 8) ? PROVIDERS - 1 : 7);
  localparam logic [IW-1:0] IDX_LAST = IW'(PROVIDERS - 1);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_MEAN_W = 17'b00000000000000010,
    S_SUM    = 17'b00000000000000100,
    S_DT_W   = 17'b00000000000001000,
    S_P_RD   = 17'b00000000000010000,
    S_P_DIV  = 17'b00000000000100000,
    S_P_W    = 17'b00000000001000000,
    S_MUL_P  = 17'b00000000010000000,
    S_MUL_D  = 17'b00000000100000000,
    S_PD_WR  = 17'b00000001000000000,
    S_N_RD   = 17'b00000010000000000,
    S_N_DIV  = 17'b00000100000000000,
    S_N_W    = 17'b00001000000000000,
    S_N_WR   = 17'b00010000000000000,
    S_R1     = 17'b00100000000000000,
    S_R2     = 17'b01000000000000000,
    S_R3     = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [23:0] k_err_q, k_d_q;
  logic [16:0] mix_q;
  logic [15:0] period_cfg_q;
  logic [3:0]  window_q;

  // state
  logic [lrc_pkg::AVG_W-1:0] avg_q [8];
  logic [31:0]               cnt_q [8];
  logic [16:0]               share_mem [PROVIDERS];
  logic [19:0]               prev_mem [PROVIDERS];
  logic [PROVIDERS-1:0]      init_q;
  logic [15:0]               period_q;
  logic                      first_q;

  // working registers
  logic [2:0]                p_q;
  logic [lrc_pkg::AVG_W-1:0] a_q, dt_q;
  logic                      up_q, neg_q, use_d_q;
  logic [IW-1:0]             idx_q;
  logic [43:0]               sum_q;
  logic signed [19:0]        drel_q;
  logic signed [30:0]        dr_q;
  logic [22:0]               total_q;
  logic [16:0]               nshare_q, share_rd_q;
  logic [19:0]               prev_rd_q;
  logic                      init_rd_q;
  logic [33:0]               acc_q;
  logic signed [46:0]        prod_q;

  logic        out_valid_q, out_last_q;
  logic [2:0]  out_prov_q;
  logic [16:0] out_ratio_q;

  // shared divider
  lrc_pkg::div_cmd_t div_cmd;
  lrc_pkg::div_rsp_t div_rsp;

  lrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  // config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_err_q      <= 24'd65536;
      k_d_q        <= '0;
      mix_q        <= '0;
      period_cfg_q <= '0;
      window_q     <= 4'd8;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        lrc_pkg::REG_K_ERR:  k_err_q      <= pwdata[23:0];
        lrc_pkg::REG_K_D:    k_d_q        <= pwdata[23:0];
        lrc_pkg::REG_MIX:    mix_q        <= pwdata[16:0];
        lrc_pkg::REG_PERIOD: period_cfg_q <= pwdata[15:0];
        lrc_pkg::REG_WINDOW: window_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      lrc_pkg::REG_K_ERR:  prdata = {8'd0, k_err_q};
      lrc_pkg::REG_K_D:    prdata = {8'd0, k_d_q};
      lrc_pkg::REG_MIX:    prdata = {15'd0, mix_q};
      lrc_pkg::REG_PERIOD: prdata = {16'd0, period_cfg_q};
      lrc_pkg::REG_WINDOW: prdata = {28'd0, window_q};
      default:             prdata = '0;
    endcase
  end

  // input decode
  logic [2:0]  in_prov;
  logic [23:0] in_lat;
  logic        in_acc, in_ok;
  assign in_prov = s_axis_tdata[2:0];
  assign in_lat  = s_axis_tdata[26:3];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_ok   = {5'd0, in_prov} < 8'(PROVIDERS);

  // single read port on the averages
  logic [7:0]                idx8;
  logic [2:0]                avg_addr;
  logic                      avg_hit;
  logic [lrc_pkg::AVG_W-1:0] avg_rd;
  assign idx8     = 8'(idx_q);
  assign avg_addr = (state_q == S_IDLE) ? in_prov : idx8[2:0];
  assign avg_hit  = (state_q == S_IDLE) || (idx8 < 8'd8);
  assign avg_rd   = avg_hit ? avg_q[avg_addr] : '0;

  // mean step
  logic [lrc_pkg::AVG_W-1:0] x_in;
  logic                      x_up;
  assign x_in = {in_lat, 16'd0};
  assign x_up = x_in >= avg_rd;

  // window
  logic [7:0] win_w, win_start;
  always_comb begin
    win_w = (window_q == 4'd0) ? 8'd1 : {4'd0, window_q};
    if (win_w > 8'(PROVIDERS)) win_w = 8'(PROVIDERS);
    win_start = 8'(PROVIDERS) - win_w;
  end

  // shared multiplier
  logic [16:0]        m_sat;
  logic signed [24:0] mul_a;
  logic signed [21:0] mul_b;
  logic               mul_en;
  assign m_sat = (mix_q > lrc_pkg::Q_ONE) ? lrc_pkg::Q_ONE : mix_q;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_MUL_P: begin
        mul_a = 25'(signed'(k_err_q));
        mul_b = 22'(drel_q);
      end
      S_MUL_D: begin
        mul_a = 25'(signed'(k_d_q));
        mul_b = 22'(drel_q) - (init_rd_q ? 22'(signed'(prev_rd_q)) : 22'sd0);
      end
      S_R1: begin
        mul_a = signed'({8'd0, m_sat});
        mul_b = signed'({5'd0, UNI});
      end
      S_R2: begin
        mul_a = signed'({8'd0, 17'(lrc_pkg::Q_ONE - m_sat)});
        mul_b = signed'({5'd0, nshare_q});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= 47'(mul_a) * 47'(mul_b);
  end

  // relative latency
  logic signed [40:0]  num;
  logic [39:0]         num_abs;
  logic [16:0]         share_rd;
  logic signed [32:0]  s_sum;
  logic [16:0]         s_clamp;
  logic [lrc_pkg::DIV_DW-1:0] q;
  assign num      = signed'({1'b0, dt_q}) - signed'({1'b0, avg_rd});
  assign num_abs  = num[40] ? 40'(-num) : num[39:0];
  assign share_rd = init_rd_q ? share_rd_q : UNI;
  assign q        = div_rsp.quotient;

  always_comb begin
    s_sum = 33'(signed'({1'b0, share_rd})) + 33'(dr_q);
    if (use_d_q) s_sum = s_sum + 33'(prod_q >>> 16);
    if (s_sum < 0) s_clamp = '0;
    else if (s_sum > 33'sd65536) s_clamp = lrc_pkg::Q_ONE;
    else s_clamp = s_sum[16:0];
  end

  // divider requests
  always_comb begin
    div_cmd = '0;
    unique case (state_q)
      S_IDLE: begin
        div_cmd.start    = in_acc && in_ok;
        div_cmd.dividend = lrc_pkg::DIV_DW'(x_up ? x_in - avg_rd : avg_rd - x_in);
        div_cmd.divisor  = lrc_pkg::DIV_SW'({1'b0, cnt_q[in_prov]} + 33'd1);
      end
      S_SUM: begin
        div_cmd.start    = (idx_q == IDX_LAST);
        div_cmd.dividend = lrc_pkg::DIV_DW'(sum_q + 44'(avg_rd));
        div_cmd.divisor  = lrc_pkg::DIV_SW'(win_w);
      end
      S_P_DIV: begin
        div_cmd.start    = (dt_q != '0);
        div_cmd.dividend = {num_abs, 16'd0};
        div_cmd.divisor  = lrc_pkg::DIV_SW'(dt_q);
      end
      S_N_DIV: begin
        div_cmd.start    = (total_q != '0);
        div_cmd.dividend = lrc_pkg::DIV_DW'({share_rd_q, 16'd0});
        div_cmd.divisor  = lrc_pkg::DIV_SW'(total_q);
      end
      default: ;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && in_ok) state_d = S_MEAN_W;
      S_MEAN_W: begin
        if (div_rsp.done) begin
          if (period_cfg_q != '0 && (period_q + 16'd1) >= period_cfg_q) state_d = S_SUM;
          else state_d = S_IDLE;
        end
      end
      S_SUM:    if (idx_q == IDX_LAST) state_d = S_DT_W;
      S_DT_W:   if (div_rsp.done) state_d = S_P_RD;
      S_P_RD:   state_d = S_P_DIV;
      S_P_DIV:  state_d = (dt_q != '0) ? S_P_W : S_MUL_P;
      S_P_W:    if (div_rsp.done) state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_D;
      S_MUL_D:  state_d = S_PD_WR;
      S_PD_WR:  state_d = (idx_q == IDX_LAST) ? S_N_RD : S_P_RD;
      S_N_RD:   state_d = S_N_DIV;
      S_N_DIV:  state_d = (total_q != '0) ? S_N_W : S_N_WR;
      S_N_W:    if (div_rsp.done) state_d = S_N_WR;
      S_N_WR: begin
        if (idx8 <= OUT_LAST) state_d = S_R1;
        else if (idx_q == IDX_LAST) state_d = S_IDLE;
        else state_d = S_N_RD;
      end
      S_R1:     state_d = S_R2;
      S_R2:     state_d = S_R3;
      S_R3: begin
        if (out_free) state_d = (idx_q == IDX_LAST) ? S_IDLE : S_N_RD;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= '0;
      first_q     <= 1'b1;
      init_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        avg_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_MEAN_W && div_rsp.done) begin
        avg_q[p_q] <= up_q ? a_q + q[lrc_pkg::AVG_W-1:0] : a_q - q[lrc_pkg::AVG_W-1:0];
        if (cnt_q[p_q] != 32'hFFFF_FFFF) cnt_q[p_q] <= cnt_q[p_q] + 32'd1;
        if (period_cfg_q != '0) begin
          period_q <= ((period_q + 16'd1) >= period_cfg_q) ? 16'd0 : period_q + 16'd1;
        end
      end
      if (state_q == S_MUL_D) first_q <= 1'b0;
      if (state_q == S_PD_WR) init_q[idx_q] <= 1'b1;
      if (state_q == S_R3 && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        p_q  <= in_prov;
        a_q  <= avg_rd;
        up_q <= x_up;
      end
      S_MEAN_W: begin
        idx_q <= win_start[IW-1:0];
        sum_q <= '0;
      end
      S_SUM: sum_q <= sum_q + 44'(avg_rd);
      S_DT_W: begin
        dt_q    <= q[lrc_pkg::AVG_W-1:0];
        idx_q   <= '0;
        total_q <= '0;
      end
      S_P_DIV: begin
        neg_q  <= num[40];
        drel_q <= '0;
      end
      S_P_W: begin
        if (!neg_q) drel_q <= (q > 56'd65536) ? 20'sd65536 : 20'(q);
        else drel_q <= (q > 56'd524288) ? -20'sd524288 : 20'(-q);
      end
      S_MUL_D: begin
        dr_q    <= 31'(prod_q >>> 16);
        use_d_q <= !first_q;
      end
      S_PD_WR: begin
        total_q <= total_q + 23'(s_clamp);
        idx_q   <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      end
      S_N_DIV: nshare_q <= UNI;
      S_N_W:   nshare_q <= q[16:0];
      S_N_WR:  if (idx8 > OUT_LAST && idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
      S_R2:    acc_q <= prod_q[33:0];
      S_R3: begin
        if (out_free) begin
          out_prov_q  <= idx8[2:0];
          out_ratio_q <= 17'((35'(acc_q) + 35'(prod_q[33:0])) >> 16);
          out_last_q  <= (idx8 == OUT_LAST);
          if (idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == S_SUM && idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
  end

  // provider memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_P_RD || state_q == S_N_RD) begin
      share_rd_q <= share_mem[idx_q];
      prev_rd_q  <= prev_mem[idx_q];
      init_rd_q  <= init_q[idx_q];
    end
    if (state_q == S_PD_WR) begin
      share_mem[idx_q] <= s_clamp;
      prev_mem[idx_q]  <= drel_q;
    end else if (state_q == S_N_WR) begin
      share_mem[idx_q] <= nshare_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_ratio_q, out_prov_q};
  assign m_axis_tlast  = out_last_q;

  `LRC_ASSERT_IMP(a_ratio_range, out_valid_q, out_ratio_q <= lrc_pkg::Q_ONE, "ratio above one")
  `LRC_ASSERT_IMP(a_first_clear, state_q == S_PD_WR, !first_q, "first update flag still set")
  `LRC_ASSERT_IMP(a_div_done_wait, div_rsp.done, state_q == S_MEAN_W || state_q == S_DT_W || state_q == S_P_W || state_q == S_N_W, "divider result with no waiter")

endmodule
